// ----- src/task_scheduler_fcfs_srtf_rr_assert.svh -----
// ----------------------------------------------------------------------------
// Task scheduler assertion macros
// Shared property forms for the scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef TASK_SCHEDULER_FCFS_SRTF_RR_ASSERT_SVH
`define TASK_SCHEDULER_FCFS_SRTF_RR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSCH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ----- src/tsch_pkg.sv -----
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared widths, codes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package tsch_pkg;

    localparam int DEF_TASK_SLOTS = 32;
    localparam int ID_W           = 5;
    localparam int BURST_W        = 16;
    localparam int CNT_W          = 24;
    localparam int ENTRY_W        = BURST_W + 2 * CNT_W;
    localparam int CFG_W          = 8;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [7:0]       RST_SLICE = 8'd4;

    // Item functions.
    localparam logic [1:0] FN_ARRIVE = 2'd0;
    localparam logic [1:0] FN_TICK   = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;

    // Scheduling modes.
    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SRTF = 2'd1;
    localparam logic [1:0] MODE_RR   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_SLICE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QRD,
        ST_SCAN,
        ST_UPD,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- src/tsch_ram.sv -----
// ----------------------------------------------------------------------------
// Task table memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tsch_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/task_scheduler_fcfs_srtf_rr.sv -----
// Arrival, an unknown item and a tick with nothing runnable go from the accepting state to
// the done state, where the result is valid; a query reads the table on the way; busy falls
// in the cycle after the result. A tick runs a selection pass and an update pass over the
// task table, one slot per cycle through its single read port; a round-robin tick that keeps
// the current task skips the selection pass.
// Reset clears control state and loaded flags; items are accepted right after.
// ----------------------------------------------------------------------------
// Task scheduler top level
// Keeps a task table in memory and runs FCFS, shortest remaining or round robin.
// ----------------------------------------------------------------------------
`default_nettype none

module task_scheduler_fcfs_srtf_rr #(
    parameter int TASK_SLOTS = tsch_pkg::DEF_TASK_SLOTS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_func,
    input  wire logic [tsch_pkg::ID_W-1:0]    i_task_id,
    input  wire logic [tsch_pkg::BURST_W-1:0] i_burst_length,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_idx,
    input  wire logic [tsch_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                              o_valid,
    output logic [tsch_pkg::ID_W-1:0]         o_run_task,
    output logic [tsch_pkg::BURST_W-1:0]      o_burst_left,
    output logic [tsch_pkg::CNT_W-1:0]        o_wait_count,
    output logic [tsch_pkg::CNT_W-1:0]        o_turnaround_count,
    output logic                              o_idle,
    output logic                              o_all_done
);

    import tsch_pkg::*;

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);
    localparam logic [CW-1:0] SCAN_LEN  = CW'(TASK_SLOTS);

    t_state r_state, n_state;

    logic [1:0]            r_mode;
    logic [7:0]            r_slice;
    logic [TASK_SLOTS-1:0] r_loaded;
    logic [TASK_SLOTS-1:0] r_runv;
    logic [SW-1:0]         r_cur;
    logic [7:0]            r_su;

    logic [SW-1:0]         r_addr;
    logic [CW-1:0]         r_cnt;
    logic                  r_rd_vld;
    logic [SW-1:0]         r_rd_addr;
    logic [SW-1:0]         r_best;
    logic [BURST_W-1:0]    r_best_burst;
    logic                  r_found;
    logic                  r_qok;

    logic [ID_W-1:0]       r_res_run;
    logic [BURST_W-1:0]    r_res_left;
    logic [CNT_W-1:0]      r_res_wc;
    logic [CNT_W-1:0]      r_res_tc;
    logic                  r_res_idle;

    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [SW-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic                  accept;
    logic                  in_range;
    logic [SW-1:0]         id_slot;
    logic [7:0]            quantum;
    logic                  rr_keep;
    logic                  pass_end;
    logic [SW-1:0]         addr_next;
    logic [SW-1:0]         cur_next;
    logic [BURST_W-1:0]    rd_burst;
    logic [CNT_W-1:0]      rd_wc;
    logic [CNT_W-1:0]      rd_tc;
    logic [BURST_W-1:0]    dec_burst;
    logic [CNT_W-1:0]      inc_wc;
    logic [CNT_W-1:0]      inc_tc;
    logic                  rd_act;
    logic                  rd_is_best;

    tsch_ram #(
        .DEPTH (TASK_SLOTS),
        .AW    (SW),
        .DW    (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Decode of the current item and the table read data.
    assign accept     = start && (r_state == ST_IDLE);
    assign in_range   = 32'(i_task_id) < TASK_SLOTS;
    assign id_slot    = SW'(i_task_id);
    assign quantum    = (r_slice == 8'd0) ? 8'd1 : r_slice;
    assign rr_keep    = r_runv[r_cur] && (r_su < quantum);
    assign pass_end   = (r_cnt == SCAN_LEN) && !r_rd_vld;
    assign addr_next  = (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
    assign cur_next   = (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;
    assign rd_burst   = ram_rdata[ENTRY_W-1 -: BURST_W];
    assign rd_wc      = ram_rdata[2*CNT_W-1 -: CNT_W];
    assign rd_tc      = ram_rdata[CNT_W-1:0];
    assign dec_burst  = rd_burst - 1'b1;
    assign inc_wc     = (rd_wc == CNT_MAX) ? rd_wc : rd_wc + 1'b1;
    assign inc_tc     = (rd_tc == CNT_MAX) ? rd_tc : rd_tc + 1'b1;
    assign rd_act     = r_runv[r_rd_addr];
    assign rd_is_best = (r_rd_addr == r_best);

    // Next state and table port control.
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_rd_addr;
        ram_wdata = {rd_is_best ? dec_burst : rd_burst,
                     rd_is_best ? rd_wc : inc_wc, inc_tc};
        ram_raddr = r_addr;
        case (r_state)
            ST_IDLE: begin
                ram_raddr = id_slot;
                if (accept) begin
                    case (i_func)
                        FN_ARRIVE: begin
                            ram_we    = in_range;
                            ram_waddr = id_slot;
                            ram_wdata = {i_burst_length, {CNT_W{1'b0}}, {CNT_W{1'b0}}};
                            n_state   = ST_DONE;
                        end
                        FN_TICK: begin
                            if (r_runv == '0) begin
                                n_state = ST_DONE;
                            end else if (r_mode == MODE_RR && rr_keep) begin
                                n_state = ST_UPD;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_QUERY: n_state = ST_QRD;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_QRD: n_state = ST_DONE;
            ST_SCAN: begin
                if (pass_end) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                ram_we = r_rd_vld && rd_act;
                if (pass_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FCFS;
            r_slice <= RST_SLICE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_wdata[1:0];
                CFG_SLICE: r_slice <= i_cfg_wdata;
                default:   r_slice <= r_slice;
            endcase
        end
    end

    // Control state: slot flags, scheduling position and pass counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_runv   <= '0;
            r_cur    <= '0;
            r_su     <= '0;
            r_addr   <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt    <= '0;
                    r_rd_vld <= 1'b0;
                    r_addr   <= (r_mode == MODE_RR && !rr_keep) ? cur_next : '0;
                    if (accept && i_func == FN_ARRIVE && in_range) begin
                        r_loaded[id_slot] <= 1'b1;
                        r_runv[id_slot]   <= (i_burst_length != '0);
                    end
                end
                ST_SCAN, ST_UPD: begin
                    if (pass_end) begin
                        r_cnt    <= '0;
                        r_addr   <= '0;
                        r_rd_vld <= 1'b0;
                    end else if (r_cnt != SCAN_LEN) begin
                        r_cnt    <= r_cnt + 1'b1;
                        r_addr   <= addr_next;
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_state == ST_UPD && r_rd_vld && rd_is_best) begin
                        r_runv[r_rd_addr] <= (dec_burst != '0);
                    end
                    // Close the tick: new current task and its slice count.
                    if (r_state == ST_UPD && pass_end) begin
                        r_cur <= r_best;
                        r_su  <= (r_best == r_cur && r_mode == MODE_RR && r_su < quantum)
                                 ? r_su + 1'b1 : 8'd1;
                    end
                end
                default: begin
                    r_rd_vld <= 1'b0;
                end
            endcase
        end
    end

    // Selection datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_addr;
        case (r_state)
            ST_IDLE: begin
                r_found    <= 1'b0;
                r_best     <= r_cur;
                r_qok      <= in_range && r_loaded[id_slot];
                r_res_run  <= (i_func == FN_ARRIVE || i_func == FN_QUERY) ? i_task_id : '0;
                r_res_left <= (i_func == FN_ARRIVE && in_range) ? i_burst_length : '0;
                r_res_wc   <= '0;
                r_res_tc   <= '0;
                r_res_idle <= 1'b1;
            end
            ST_QRD: begin
                if (r_qok) begin
                    r_res_left <= rd_burst;
                    r_res_wc   <= rd_wc;
                    r_res_tc   <= rd_tc;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && rd_act) begin
                    if (!r_found || (r_mode == MODE_SRTF && rd_burst < r_best_burst)) begin
                        r_found      <= 1'b1;
                        r_best       <= r_rd_addr;
                        r_best_burst <= rd_burst;
                    end
                end
            end
            ST_UPD: begin
                if (r_rd_vld && rd_is_best) begin
                    r_res_run  <= ID_W'(r_rd_addr);
                    r_res_left <= rd_burst;
                    r_res_wc   <= rd_wc;
                    r_res_tc   <= rd_tc;
                    r_res_idle <= 1'b0;
                end
            end
            default: begin
                r_found <= r_found;
            end
        endcase
    end

    // Result ports.
    assign busy               = (r_state != ST_IDLE);
    assign o_valid            = (r_state == ST_DONE);
    assign o_run_task         = r_res_run;
    assign o_burst_left       = r_res_left;
    assign o_wait_count       = r_res_wc;
    assign o_turnaround_count = r_res_tc;
    assign o_idle             = r_res_idle;
    assign o_all_done         = (r_runv == '0);

endmodule

`default_nettype wire

// ----- src/tsch_chk.sv -----
// ----------------------------------------------------------------------------
// Task scheduler port checker
// Watches the top-level ports for handshake and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "task_scheduler_fcfs_srtf_rr_assert.svh"

module tsch_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_start,
    input wire logic                         i_busy,
    input wire logic                         i_valid,
    input wire logic                         i_idle,
    input wire logic [tsch_pkg::BURST_W-1:0] i_burst_left
);

    // A result transaction lasts exactly one cycle.
    `TSCH_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, i_valid, !i_valid)

    // An accepted item keeps the block busy on the next cycle.
    `TSCH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)

    // A result only appears while an item is in work.
    `TSCH_ASSERT_SAME(a_valid_busy, i_clk, i_rst_n, i_valid, i_busy)

    // A task that ran on a tick had burst left before it.
    `TSCH_ASSERT_SAME(a_run_burst, i_clk, i_rst_n, i_valid && !i_idle, i_burst_left != '0)

endmodule

bind task_scheduler_fcfs_srtf_rr tsch_chk u_tsch_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (start),
    .i_busy       (busy),
    .i_valid      (o_valid),
    .i_idle       (o_idle),
    .i_burst_left (o_burst_left)
);

`default_nettype wire
